@@ src/bsp_pkg.sv @@
// Shared types and constants for the beam search path finder.
// No dependencies; used by bsp_ctrl, bsp_datapath and the top level.
package bsp_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEF_NUM_NODES  = 16;
  localparam int DEF_MAX_DEGREE = 4;
  localparam int DEF_MAX_BEAM   = 4;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int NODE_W   = 4;
  localparam int SLOT_W   = 2;
  localparam int WEIGHT_W = 8;
  localparam int HEUR_W   = 8;
  localparam int COST_W   = 12;
  localparam int EST_W    = 13;
  localparam int BW_W     = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [COST_W-1:0] COST_MAX = 12'hFFF;
  localparam logic [BW_W-1:0] BEAM_WIDTH_RESET = 3'd2;

  // At most this many result items per search
  localparam int RESULT_LIMIT = 16;
  localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

  // Input item function codes
  localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEUR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_EXPAND,
    ST_DRAIN,
    ST_SELECT,
    ST_EMIT,
    ST_FAIL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic exp_start;
    logic exp_step;
    logic select;
    logic emit_start;
    logic emit_step;
    logic emit_fail;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad_ends;
    logic round_over;
    logic goal_hit;
    logic issue_done;
    logic cand_none;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

@@ src/bsp_ctrl.sv @@
// Search sequencer for the beam search path finder.
// Depends on bsp_pkg for the state, command and status types.
module bsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_take,
  input  logic             in_search,
  input  bsp_pkg::status_t stat,
  output bsp_pkg::cmd_t    cmd,
  output bsp_pkg::state_t  state,
  output logic             in_ready
);

  bsp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bsp_pkg::ST_IDLE: begin
        if (in_take && in_search) state_next = bsp_pkg::ST_INIT;
      end
      bsp_pkg::ST_INIT: begin
        state_next = stat.bad_ends ? bsp_pkg::ST_FAIL : bsp_pkg::ST_CHECK;
      end
      bsp_pkg::ST_CHECK: begin
        if (stat.round_over) state_next = bsp_pkg::ST_FAIL;
        else if (stat.goal_hit) state_next = bsp_pkg::ST_EMIT;
        else state_next = bsp_pkg::ST_EXPAND;
      end
      bsp_pkg::ST_EXPAND: begin
        if (stat.issue_done) state_next = bsp_pkg::ST_DRAIN;
      end
      bsp_pkg::ST_DRAIN: state_next = bsp_pkg::ST_SELECT;
      bsp_pkg::ST_SELECT: begin
        state_next = stat.cand_none ? bsp_pkg::ST_FAIL : bsp_pkg::ST_CHECK;
      end
      bsp_pkg::ST_EMIT: begin
        if (stat.out_free && stat.emit_last) state_next = bsp_pkg::ST_IDLE;
      end
      bsp_pkg::ST_FAIL: begin
        if (stat.out_free) state_next = bsp_pkg::ST_IDLE;
      end
      default: state_next = bsp_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_take && in_search;
      end
      bsp_pkg::ST_INIT:   cmd.init = !stat.bad_ends;
      bsp_pkg::ST_CHECK: begin
        cmd.emit_start = !stat.round_over && stat.goal_hit;
        cmd.exp_start  = !stat.round_over && !stat.goal_hit;
      end
      bsp_pkg::ST_EXPAND: cmd.exp_step = 1'b1;
      bsp_pkg::ST_DRAIN:  cmd = '0;
      bsp_pkg::ST_SELECT: cmd.select = !stat.cand_none;
      bsp_pkg::ST_EMIT:   cmd.emit_step = stat.out_free;
      bsp_pkg::ST_FAIL:   cmd.emit_fail = stat.out_free;
      default:            cmd = '0;
    endcase
  end

endmodule

@@ src/bsp_datapath.sv @@
// Tables, beam rows, candidate list and output register of the path finder.
// Depends on bsp_pkg; driven by bsp_ctrl commands.
module bsp_datapath #(
  parameter int NUM_NODES  = bsp_pkg::DEF_NUM_NODES,
  parameter int MAX_DEGREE = bsp_pkg::DEF_MAX_DEGREE,
  parameter int MAX_BEAM   = bsp_pkg::DEF_MAX_BEAM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bsp_pkg::cmd_t               cmd,
  output bsp_pkg::status_t            stat,
  input  logic                        cfg_we,
  input  logic [bsp_pkg::BW_W-1:0]    cfg_wdata,
  input  logic                        in_take,
  input  logic [bsp_pkg::FUNC_W-1:0]  func,
  input  logic [bsp_pkg::NODE_W-1:0]  node,
  input  logic [bsp_pkg::SLOT_W-1:0]  edge_slot,
  input  logic                        edge_present,
  input  logic [bsp_pkg::NODE_W-1:0]  neighbor,
  input  logic [bsp_pkg::WEIGHT_W-1:0] weight,
  input  logic [bsp_pkg::HEUR_W-1:0]  heur_value,
  input  logic [bsp_pkg::NODE_W-1:0]  start_node,
  input  logic [bsp_pkg::NODE_W-1:0]  goal_node,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        found,
  output logic [bsp_pkg::NODE_W-1:0]  path_node,
  output logic [bsp_pkg::COST_W-1:0]  total_cost,
  output logic                        last
);

  localparam int NIDX_W  = $clog2(NUM_NODES);
  localparam int LEN_W   = $clog2(NUM_NODES + 1);
  localparam int EDGES   = NUM_NODES * MAX_DEGREE;
  localparam int EADDR_W = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int BIDX_W  = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
  localparam int KW      = $clog2(MAX_BEAM + 1);
  localparam int DEG_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int RND_W   = $clog2(NUM_NODES + 2);
  localparam int EW_W    = bsp_pkg::NODE_W + bsp_pkg::WEIGHT_W;

  // Graph tables
  logic [EW_W-1:0]              edge_mem [EDGES];
  logic [EDGES-1:0]             edge_valid;
  logic [bsp_pkg::HEUR_W-1:0]   heur [NUM_NODES];
  logic [bsp_pkg::BW_W-1:0]     beam_width;

  // Beam rows, one register per beam holding all its path nodes
  logic [NUM_NODES*bsp_pkg::NODE_W-1:0] path [MAX_BEAM];
  logic [LEN_W-1:0]             plen  [MAX_BEAM];
  logic [bsp_pkg::COST_W-1:0]   pcost [MAX_BEAM];
  logic [NUM_NODES-1:0]         pmask [MAX_BEAM];
  logic [KW-1:0]                beam_count;
  logic [RND_W-1:0]             round;

  // Sorted candidate list
  logic [BIDX_W-1:0]            cpar  [MAX_BEAM];
  logic [bsp_pkg::NODE_W-1:0]   cnode [MAX_BEAM];
  logic [bsp_pkg::COST_W-1:0]   ccost [MAX_BEAM];
  logic [bsp_pkg::EST_W-1:0]    cest  [MAX_BEAM];
  logic [KW-1:0]                ccnt;

  logic [bsp_pkg::NODE_W-1:0]   s_node, g_node;
  logic [BIDX_W-1:0]            eb;
  logic [DEG_W-1:0]             ek;
  logic                         p_valid, p_ev;
  logic [BIDX_W-1:0]            p_beam;
  logic [EW_W-1:0]              edge_rd;
  logic [BIDX_W-1:0]            hit_beam;
  logic [bsp_pkg::EMIT_W-1:0]   ecnt;

  logic [bsp_pkg::NODE_W-1:0]   tail [MAX_BEAM];
  logic [KW-1:0]                bw_eff;
  logic                         goal_hit;
  logic [BIDX_W-1:0]            hit_sel;
  logic [EADDR_W-1:0]           wr_addr, rd_addr;
  logic                         tbl_edge, tbl_heur, issue_ok;
  logic [bsp_pkg::NODE_W-1:0]   c_t;
  logic [bsp_pkg::WEIGHT_W-1:0] c_w;
  logic [bsp_pkg::COST_W:0]     c_sum;
  logic [bsp_pkg::COST_W-1:0]   c_cost;
  logic [bsp_pkg::EST_W-1:0]    c_est;
  logic                         c_ok;
  logic [KW-1:0]                pos;
  logic [bsp_pkg::EMIT_W-1:0]   en;
  logic [LEN_W-1:0]             hlen;

  // Effective beam width
  always_comb begin
    if (beam_width == '0) bw_eff = KW'(1);
    else if (int'(beam_width) > MAX_BEAM) bw_eff = KW'(MAX_BEAM);
    else bw_eff = KW'(beam_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_width <= bsp_pkg::BEAM_WIDTH_RESET;
    end else if (cfg_we) begin
      beam_width <= cfg_wdata;
    end
  end

  // Table writes
  assign tbl_edge = in_take && (func == bsp_pkg::FUNC_EDGE) && (int'(node) < NUM_NODES)
                    && (int'(edge_slot) < MAX_DEGREE);
  assign tbl_heur = in_take && (func == bsp_pkg::FUNC_HEUR) && (int'(node) < NUM_NODES);
  assign wr_addr  = EADDR_W'(int'(node) * MAX_DEGREE + int'(edge_slot));

  always_ff @(posedge clk) begin
    if (tbl_edge) begin
      edge_mem[wr_addr] <= {neighbor, weight};
    end
    edge_rd <= edge_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid <= '0;
      for (int i = 0; i < NUM_NODES; i++) heur[i] <= '0;
    end else begin
      if (tbl_edge) edge_valid[wr_addr] <= edge_present;
      if (tbl_heur) heur[NIDX_W'(node)] <= heur_value;
    end
  end

  // Last node of each beam and goal check
  always_comb begin
    goal_hit = 1'b0;
    hit_sel  = '0;
    for (int b = 0; b < MAX_BEAM; b++) begin
      tail[b] = path[b][int'(NIDX_W'(plen[b] - LEN_W'(1))) * bsp_pkg::NODE_W
                        +: bsp_pkg::NODE_W];
    end
    for (int b = MAX_BEAM - 1; b >= 0; b--) begin
      if ((KW'(b) < beam_count) && (plen[b] != '0) && (tail[b] == g_node)) begin
        goal_hit = 1'b1;
        hit_sel  = BIDX_W'(b);
      end
    end
  end

  // Edge read issue
  assign rd_addr  = EADDR_W'(int'(tail[eb]) * MAX_DEGREE + int'(ek));
  assign issue_ok = cmd.exp_step && (int'(plen[eb]) < NUM_NODES) && (plen[eb] != '0);

  // Candidate evaluation on the registered edge read
  always_comb begin
    c_t    = edge_rd[EW_W-1:bsp_pkg::WEIGHT_W];
    c_w    = edge_rd[bsp_pkg::WEIGHT_W-1:0];
    c_sum  = {1'b0, pcost[p_beam]} + (bsp_pkg::COST_W + 1)'(c_w);
    c_cost = (c_sum > {1'b0, bsp_pkg::COST_MAX}) ? bsp_pkg::COST_MAX
                                                 : c_sum[bsp_pkg::COST_W-1:0];
    c_est  = bsp_pkg::EST_W'(c_cost) + bsp_pkg::EST_W'(heur[NIDX_W'(c_t)]);
    c_ok   = p_valid && p_ev && (int'(c_t) < NUM_NODES) && !pmask[p_beam][NIDX_W'(c_t)];
    pos    = '0;
    for (int i = 0; i < MAX_BEAM; i++) begin
      if ((KW'(i) < ccnt) && (cest[i] <= c_est)) pos = pos + KW'(1);
    end
  end

  // Expansion counters and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue_ok;
    end
    p_beam <= eb;
    p_ev   <= edge_valid[rd_addr];
    if (cmd.exp_start) begin
      eb <= '0;
      ek <= '0;
    end else if (cmd.exp_step) begin
      if (int'(ek) == MAX_DEGREE - 1) begin
        ek <= '0;
        eb <= eb + BIDX_W'(1);
      end else begin
        ek <= ek + DEG_W'(1);
      end
    end
  end

  // Insert candidate into the sorted list, dropping anything past the width
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
    end else if (cmd.exp_start) begin
      ccnt <= '0;
    end else if (c_ok && (pos < bw_eff)) begin
      ccnt <= (ccnt < bw_eff) ? ccnt + KW'(1) : ccnt;
    end
    if (!cmd.exp_start && c_ok && (pos < bw_eff)) begin
      for (int i = 0; i < MAX_BEAM; i++) begin
        if (KW'(i) == pos) begin
          cpar[i]  <= p_beam;
          cnode[i] <= c_t;
          ccost[i] <= c_cost;
          cest[i]  <= c_est;
        end else if ((KW'(i) > pos) && (i > 0)) begin
          cpar[i]  <= cpar[(i > 0) ? i - 1 : 0];
          cnode[i] <= cnode[(i > 0) ? i - 1 : 0];
          ccost[i] <= ccost[(i > 0) ? i - 1 : 0];
          cest[i]  <= cest[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Beam rows: init from the start node, or rebuild from the kept candidates
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_count <= '0;
      round      <= '0;
    end else if (cmd.init) begin
      beam_count <= KW'(1);
      round      <= '0;
    end else if (cmd.select) begin
      beam_count <= ccnt;
      round      <= round + RND_W'(1);
    end
    if (cmd.load) begin
      s_node <= start_node;
      g_node <= goal_node;
    end
    if (cmd.init) begin
      path[0][bsp_pkg::NODE_W-1:0] <= s_node;
      plen[0]    <= LEN_W'(1);
      pcost[0]   <= '0;
      pmask[0]   <= NUM_NODES'(1) << s_node;
    end else if (cmd.select) begin
      for (int k = 0; k < MAX_BEAM; k++) begin
        if (KW'(k) < ccnt) begin
          for (int j = 0; j < NUM_NODES; j++) begin
            path[k][j*bsp_pkg::NODE_W +: bsp_pkg::NODE_W] <=
              (LEN_W'(j) == plen[cpar[k]]) ? cnode[k]
                                           : path[cpar[k]][j*bsp_pkg::NODE_W +: bsp_pkg::NODE_W];
          end
          plen[k]  <= plen[cpar[k]] + LEN_W'(1);
          pcost[k] <= ccost[k];
          pmask[k] <= pmask[cpar[k]] | (NUM_NODES'(1) << cnode[k]);
        end
      end
    end
  end

  // Result emission
  assign hlen = plen[hit_beam];
  assign en   = (int'(hlen) > bsp_pkg::RESULT_LIMIT) ? bsp_pkg::EMIT_W'(bsp_pkg::RESULT_LIMIT)
                                                     : bsp_pkg::EMIT_W'(hlen);

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      hit_beam <= hit_sel;
      ecnt     <= '0;
    end else if (cmd.emit_step) begin
      ecnt <= ecnt + bsp_pkg::EMIT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step || cmd.emit_fail) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_step) begin
      found      <= 1'b1;
      path_node  <= path[hit_beam][int'(NIDX_W'(ecnt)) * bsp_pkg::NODE_W +: bsp_pkg::NODE_W];
      total_cost <= pcost[hit_beam];
      last       <= stat.emit_last;
    end else if (cmd.emit_fail) begin
      found      <= 1'b0;
      path_node  <= '0;
      total_cost <= '0;
      last       <= 1'b1;
    end
  end

  // Status
  always_comb begin
    stat.bad_ends   = (int'(s_node) >= NUM_NODES) || (int'(g_node) >= NUM_NODES);
    stat.round_over = int'(round) > NUM_NODES;
    stat.goal_hit   = goal_hit;
    stat.issue_done = (int'(eb) + 1 == int'(beam_count)) && (int'(ek) == MAX_DEGREE - 1);
    stat.cand_none  = (ccnt == '0);
    stat.emit_last  = (ecnt + bsp_pkg::EMIT_W'(1)) == en;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

@@ src/beam_search_path_finder.sv @@
// Top level of the beam search path finder: ports, field packing, checks.
// Depends on bsp_pkg, bsp_ctrl and bsp_datapath.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser=func, tdata=table and search fields
//  m_*     | out | m_tvalid/m_tready  | tuser=found, tdata=node+cost, tlast=last
//  cfg_*   | in  | cfg_we             | cfg_wdata=beam_width
//
// A search runs rounds of check, expansion (one edge table read per cycle over
// each beam's MAX_DEGREE edge slots), drain and select, then emits its result
// items one at a time while the output is free. Reset (rst, synchronous) clears
// the edge valid bits, the heuristics and the controller; beam_width resets to 2.
// Input is taken only between searches; a stalled output holds the sequencer.
module beam_search_path_finder #(
  parameter int NUM_NODES  = bsp_pkg::DEF_NUM_NODES,
  parameter int MAX_DEGREE = bsp_pkg::DEF_MAX_DEGREE,
  parameter int MAX_BEAM   = bsp_pkg::DEF_MAX_BEAM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // node, edge_slot, edge_present, neighbor, weight, heur_value, start_node, goal_node
  input  logic [bsp_pkg::IN_DATA_W-1:0]   s_tdata,
  // func
  input  logic [bsp_pkg::FUNC_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // path_node, total_cost
  output logic [bsp_pkg::OUT_DATA_W-1:0]  m_tdata,
  // found
  output logic [0:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::BW_W-1:0]        cfg_wdata
);

  bsp_pkg::cmd_t    cmd;
  bsp_pkg::status_t stat;
  bsp_pkg::state_t  state;
  logic             in_take;
  logic             found;
  logic [bsp_pkg::NODE_W-1:0] path_node;
  logic [bsp_pkg::COST_W-1:0] total_cost;

  assign in_take = s_tvalid && s_tready;

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_search (s_tuser == bsp_pkg::FUNC_SEARCH),
    .stat      (stat),
    .cmd       (cmd),
    .state     (state),
    .in_ready  (s_tready)
  );

  bsp_datapath #(
    .NUM_NODES  (NUM_NODES),
    .MAX_DEGREE (MAX_DEGREE),
    .MAX_BEAM   (MAX_BEAM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_take      (in_take),
    .func         (s_tuser),
    .node         (s_tdata[3:0]),
    .edge_slot    (s_tdata[5:4]),
    .edge_present (s_tdata[6]),
    .neighbor     (s_tdata[10:7]),
    .weight       (s_tdata[18:11]),
    .heur_value   (s_tdata[26:19]),
    .start_node   (s_tdata[30:27]),
    .goal_node    (s_tdata[34:31]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .found        (found),
    .path_node    (path_node),
    .total_cost   (total_cost),
    .last         (m_tlast)
  );

  assign m_tdata = {total_cost, path_node};
  assign m_tuser = found;

  // A not-found item is a lone zero item
  a_fail_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
    else $error("not-found item malformed");

  // Results load only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_step || cmd.emit_fail) |-> stat.out_free)
    else $error("result loaded over a waiting item");

  // A search item closes the input until the search ends
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && (s_tuser == bsp_pkg::FUNC_SEARCH)) |=> !s_tready)
    else $error("input open during search");

  // Input is open only while the sequencer is idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == bsp_pkg::ST_IDLE))
    else $error("input open outside idle");

endmodule

@@ verif/tb_top.sv @@
// Testbench for beam_search_path_finder: streams table writes and searches,
// predicts result items in-bench and checks them field by field.
// Depends on bsp_pkg and the RTL of the path finder.
`timescale 1ns / 100ps

module tb_top;

  localparam int NN = 16;
  localparam int DEG = 4;
  localparam int BEAMS = 4;

  // Function code with no meaning to the block
  localparam logic [bsp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [bsp_pkg::FUNC_W-1:0] func;
    logic [3:0] node;
    logic [1:0] slot;
    logic       present;
    logic [3:0] nbr;
    logic [7:0] weight;
    logic [7:0] heur;
    logic [3:0] start;
    logic [3:0] goal;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  pnode;
    logic [11:0] cost;
    logic        last;
  } hop_t;

  // Directed row: request plus an optional typed-in answer
  typedef struct {
    req_t req;
    logic has_ans;
    hop_t ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [bsp_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [bsp_pkg::FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [bsp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 0;
  logic [bsp_pkg::BW_W-1:0] cfg_wdata = '0;

  beam_search_path_finder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Shadow copy of the graph tables and beam width
  logic       g_valid [NN*DEG];
  logic [3:0] g_tgt [NN*DEG];
  logic [7:0] g_cost [NN*DEG];
  logic [7:0] g_heur [NN];
  logic [2:0] bw_reg;

  hop_t path_q[$];
  row_t dir[$];
  int   errors = 0;
  logic hold_off = 0;
  logic done = 0;

  task automatic report(input string what, input hop_t got, input hop_t want);
    errors++;
    $display("mismatch %s: got f%0d n%0d c%0d l%0d want f%0d n%0d c%0d l%0d", what,
             got.found, got.pnode, got.cost, got.last,
             want.found, want.pnode, want.cost, want.last);
  endtask

  // Append one expected result item
  task automatic queue_hop(input hop_t h);
    path_q = {path_q, h};
  endtask

  // Append one directed row
  task automatic add_row(input req_t r, input logic has, input hop_t a);
    row_t rw;
    rw.req = r;
    rw.has_ans = has;
    rw.ans = a;
    dir = {dir, rw};
  endtask

  // Beam search prediction; appends the result items to path_q
  task automatic predict_search(input logic [3:0] s, input logic [3:0] g);
    logic [3:0] bn [BEAMS][NN];
    int blen [BEAMS], bcost [BEAMS];
    logic [NN-1:0] bmask [BEAMS];
    logic [3:0] nn_ [BEAMS][NN];
    int nlen [BEAMS], ncost [BEAMS];
    logic [NN-1:0] nmask [BEAMS];
    int cp [16], cn [16], cc [16], ce [16], ord [16];
    int bw, cnt, nc, keep, j, idx, c, n, hit;
    hop_t h;
    bw = (bw_reg == 0) ? 1 : (bw_reg > BEAMS ? BEAMS : int'(bw_reg));
    cnt = 1; bn[0][0] = s; blen[0] = 1; bcost[0] = 0; bmask[0] = '0; bmask[0][s] = 1;
    hit = -1;
    for (int r = 0; r <= NN && hit < 0; r++) begin
      for (int b = 0; b < cnt && hit < 0; b++)
        if (bn[b][blen[b]-1] == g) hit = b;
      if (hit >= 0) break;
      nc = 0;
      for (int b = 0; b < cnt; b++) begin
        if (blen[b] >= NN) continue;
        for (int k = 0; k < DEG; k++) begin
          idx = bn[b][blen[b]-1] * DEG + k;
          if (!g_valid[idx] || bmask[b][g_tgt[idx]] || nc >= 16) continue;
          c = bcost[b] + g_cost[idx];
          if (c > 4095) c = 4095;
          cp[nc] = b; cn[nc] = g_tgt[idx]; cc[nc] = c; ce[nc] = c + g_heur[g_tgt[idx]];
          nc++;
        end
      end
      if (nc == 0) break;
      for (int k = 0; k < nc; k++) begin
        j = k;
        while (j > 0 && ce[ord[j-1]] > ce[k]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = k;
      end
      keep = nc < bw ? nc : bw;
      for (int k = 0; k < keep; k++) begin
        nn_[k] = bn[cp[ord[k]]];
        nn_[k][blen[cp[ord[k]]]] = 4'(cn[ord[k]]);
        nlen[k] = blen[cp[ord[k]]] + 1;
        ncost[k] = cc[ord[k]];
        nmask[k] = bmask[cp[ord[k]]];
        nmask[k][cn[ord[k]]] = 1;
      end
      for (int k = 0; k < keep; k++) begin
        bn[k] = nn_[k]; blen[k] = nlen[k]; bcost[k] = ncost[k]; bmask[k] = nmask[k];
      end
      cnt = keep;
    end
    if (hit < 0) begin
      h = '{found: 0, pnode: 0, cost: 0, last: 1};
      queue_hop(h);
    end else begin
      n = blen[hit] > 16 ? 16 : blen[hit];
      for (int k = 0; k < n; k++) begin
        h = '{found: 1, pnode: bn[hit][k], cost: bcost[hit][11:0], last: (k == n-1)};
        queue_hop(h);
      end
    end
  endtask

  task automatic apply(input req_t r);
    case (r.func)
      bsp_pkg::FUNC_EDGE: begin
        g_valid[r.node*DEG+r.slot] = r.present;
        g_tgt[r.node*DEG+r.slot] = r.nbr;
        g_cost[r.node*DEG+r.slot] = r.weight;
      end
      bsp_pkg::FUNC_HEUR: g_heur[r.node] = r.heur;
      bsp_pkg::FUNC_SEARCH: predict_search(r.start, r.goal);
      default: ;
    endcase
  endtask

  // Offer one item after an optional random gap, wait for acceptance
  task automatic send(input req_t r);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= r.func;
    s_tdata <= {5'd0, r.goal, r.start, r.heur, r.weight, r.nbr, r.present, r.slot, r.node};
    do @(posedge clk); while (!s_tready);
  endtask

  // Close the input and wait for every expected item
  task automatic drain();
    s_tvalid <= 0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(input logic [2:0] w);
    cfg_we <= 1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 0;
    bw_reg = w;
  endtask

  function automatic req_t edge_req(int n, int s, int p, int t, int w);
    req_t r = '0;
    r.func = bsp_pkg::FUNC_EDGE; r.node = 4'(n); r.slot = 2'(s); r.present = 1'(p);
    r.nbr = 4'(t); r.weight = 8'(w);
    return r;
  endfunction

  function automatic req_t heur_req(int n, int v);
    req_t r = '0;
    r.func = bsp_pkg::FUNC_HEUR; r.node = 4'(n); r.heur = 8'(v);
    return r;
  endfunction

  function automatic req_t srch(int s, int g);
    req_t r = '0;
    r.func = bsp_pkg::FUNC_SEARCH; r.start = 4'(s); r.goal = 4'(g);
    return r;
  endfunction

  // Well-formed random content: mostly a forward-leaning graph
  function automatic req_t rand_req();
    req_t r;
    int k = $urandom_range(0, 99);
    r = req_t'({$urandom, $urandom});
    if (k < 55) begin
      r.func = bsp_pkg::FUNC_EDGE;
      r.present = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) r.nbr = 4'(r.node + $urandom_range(1, 3));
    end else if (k < 75) r.func = bsp_pkg::FUNC_HEUR;
    else if (k < 97) r.func = bsp_pkg::FUNC_SEARCH;
    else r.func = FUNC_UNUSED;
    return r;
  endfunction

  // Receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !hold_off && ($urandom_range(0, 9) < 7 || done);
  end

  // Result checker
  always @(posedge clk) begin
    hop_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{found: m_tuser[0], pnode: m_tdata[3:0], cost: m_tdata[15:4], last: m_tlast};
      if (path_q.size() == 0) report("unexpected item", got, got);
      else begin
        want = path_q.pop_front();
        if (got.found !== want.found) report("found", got, want);
        if (got.pnode !== want.pnode) report("path_node", got, want);
        if (got.cost !== want.cost) report("total_cost", got, want);
        if (got.last !== want.last) report("last", got, want);
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    req_t r3;
    req_t r;
    hop_t nf;
    int bws[5] = '{1, 4, 0, 7, 3};
    for (int i = 0; i < NN*DEG; i++) begin
      g_valid[i] = 0; g_tgt[i] = 0; g_cost[i] = 0;
    end
    for (int i = 0; i < NN; i++) g_heur[i] = 0;
    bw_reg = bsp_pkg::BEAM_WIDTH_RESET;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    nf = '{found: 0, pnode: 0, cost: 0, last: 1};
    // Directed table: empty graph, start equals goal, extremes, unused code
    add_row(srch(0, 15), 1, nf);
    add_row(srch(15, 15), 1, '{found: 1, pnode: 15, cost: 0, last: 1});
    add_row(edge_req(0, 0, 1, 1, 255), 0, nf);
    add_row(edge_req(0, 3, 1, 2, 0), 0, nf);
    add_row(edge_req(1, 1, 1, 15, 255), 0, nf);
    add_row(edge_req(2, 2, 1, 15, 1), 0, nf);
    add_row(edge_req(2, 0, 1, 0, 5), 0, nf);
    add_row(heur_req(1, 255), 0, nf);
    add_row(heur_req(2, 0), 0, nf);
    add_row(srch(0, 15), 0, nf);
    add_row(edge_req(2, 2, 0, 15, 1), 0, nf);
    add_row(srch(0, 15), 0, nf);
    add_row(srch(15, 0), 1, nf);
    r3 = srch(0, 15); r3.func = FUNC_UNUSED;
    add_row(r3, 0, nf);
    // Long chain of maximum-weight edges up to the last node
    for (int n = 3; n < 15; n++) add_row(edge_req(n, 1, 1, n+1, 255), 0, nf);
    add_row(edge_req(1, 0, 1, 3, 255), 0, nf);
    add_row(srch(0, 15), 0, nf);

    foreach (dir[i]) begin
      if (dir[i].has_ans) queue_hop(dir[i].ans);
      else apply(dir[i].req);
      send(dir[i].req);
    end
    drain();

    // Long receiver hold-off while items keep coming
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) begin
        apply(srch(0, 15));
        send(srch(0, 15));
      end
    join
    drain();

    // Random phases across beam widths
    foreach (bws[p]) begin
      set_width(3'(bws[p]));
      for (int i = 0; i < 65; i++) begin
        r = rand_req();
        apply(r);
        send(r);
      end
      drain();
    end
    done = 1;
    if (errors == 0 && path_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
src/bsp_pkg.sv
src/bsp_ctrl.sv
src/bsp_datapath.sv
src/beam_search_path_finder.sv
verif/tb_top.sv
